### hw/rtl/bup_pkg.sv
// ----------------------------------------------------------------------------
// bup_pkg: shared constants and types of the bilinear upscale window
// Frame and scale sizes, derived widths, the fixed-point divide constants
// and the cell word passed from the front end to the point generator.
// ----------------------------------------------------------------------------
package bup_pkg;

    localparam int RAW_HEIGHT = 16;
    localparam int RAW_WIDTH  = 16;
    localparam int SCALE_H    = 4;
    localparam int SCALE_V    = 4;

    localparam int PIX_W = 8;
    localparam int CRD_W = 6;

    localparam int ROW_W = $clog2(RAW_HEIGHT);
    localparam int COL_W = $clog2(RAW_WIDTH);

    // sub-cell position counters
    localparam int X_W = (SCALE_H > 1) ? $clog2(SCALE_H) : 1;
    localparam int Y_W = (SCALE_V > 1) ? $clog2(SCALE_V) : 1;

    // per-axis weights run 0..SCALE, their product is the corner weight
    localparam int WX_W = $clog2(SCALE_H + 1);
    localparam int WY_W = $clog2(SCALE_V + 1);
    localparam int W_W  = WX_W + WY_W;

    // weighted sum stays below 256 * NPTS
    localparam int NPTS  = SCALE_H * SCALE_V;
    localparam int HALF  = NPTS / 2;
    localparam int SUM_W = PIX_W + $clog2(NPTS);

    // floor reciprocal of NPTS, exact after one correction step
    localparam int RCP_SH = SUM_W;
    localparam int RCP    = (2 ** RCP_SH) / NPTS;
    localparam int RCP_W  = RCP_SH + 1;
    localparam int QE_W   = PIX_W + 1;

    localparam int THRESH_RST = 5;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] c;
        logic [PIX_W-1:0] d;
        logic             active;
        logic [CRD_W-1:0] row;
        logic [CRD_W-1:0] col;
    } t_cell;

endpackage

### hw/rtl/bup_front.sv
// ----------------------------------------------------------------------------
// bup_front: pixel intake and window capture
// Tracks the raw position, keeps the previous raw line, the left and the
// diagonal pixel, and pushes one cell word per completed 2x2 window.
// ----------------------------------------------------------------------------
module bup_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [bup_pkg::PIX_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [bup_pkg::PIX_W-1:0] i_pixel,
    input  logic                      i_q_full,
    output logic                      o_push,
    output bup_pkg::t_cell            o_cell
);

    localparam int ROWP_W = bup_pkg::ROW_W + bup_pkg::CRD_W;
    localparam int COLP_W = bup_pkg::COL_W + bup_pkg::CRD_W;

    logic [bup_pkg::PIX_W-1:0] r_thresh;
    logic [bup_pkg::ROW_W-1:0] r_row, n_row;
    logic [bup_pkg::COL_W-1:0] r_col, n_col;
    logic [bup_pkg::PIX_W-1:0] r_line [bup_pkg::RAW_WIDTH];
    logic [bup_pkg::PIX_W-1:0] r_left;
    logic [bup_pkg::PIX_W-1:0] r_diag;

    logic                      w_accept;
    logic [bup_pkg::PIX_W-1:0] w_above;
    logic [bup_pkg::ROW_W-1:0] w_row_m1;
    logic [bup_pkg::COL_W-1:0] w_col_m1;
    logic [ROWP_W-1:0]         w_row_base;
    logic [COLP_W-1:0]         w_col_base;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_q_full;
    assign w_accept    = i_in_valid && !i_q_full;
    assign w_above     = r_line[r_col];

    assign w_row_m1   = r_row - 1'b1;
    assign w_col_m1   = r_col - 1'b1;
    assign w_row_base = ROWP_W'(w_row_m1) * ROWP_W'(bup_pkg::SCALE_V);
    assign w_col_base = COLP_W'(w_col_m1) * COLP_W'(bup_pkg::SCALE_H);

    // a window completes once both coordinates are past the first line/column
    assign o_push        = w_accept && (r_row != '0) && (r_col != '0);
    assign o_cell.a      = r_diag;
    assign o_cell.b      = w_above;
    assign o_cell.c      = r_left;
    assign o_cell.d      = i_pixel;
    assign o_cell.active = (r_diag > r_thresh);
    assign o_cell.row    = w_row_base[bup_pkg::CRD_W-1:0];
    assign o_cell.col    = w_col_base[bup_pkg::CRD_W-1:0];

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (w_accept) begin
            if (r_col == bup_pkg::COL_W'(bup_pkg::RAW_WIDTH - 1)) begin
                n_col = '0;
                if (r_row == bup_pkg::ROW_W'(bup_pkg::RAW_HEIGHT - 1)) begin
                    n_row = '0;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= bup_pkg::PIX_W'(bup_pkg::THRESH_RST);
            r_row    <= '0;
            r_col    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_thresh <= i_cfg_data;
            end
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_diag        <= w_above;
            r_left        <= i_pixel;
            r_line[r_col] <= i_pixel;
        end
    end

endmodule

### hw/rtl/bup_queue.sv
// ----------------------------------------------------------------------------
// bup_queue: cell word queue
// Short FIFO between window capture and the point generator.
// ----------------------------------------------------------------------------
module bup_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bup_pkg::t_cell i_cell,
    output logic           o_full,
    input  logic           i_pop,
    output bup_pkg::t_cell o_cell,
    output logic           o_empty
);

    bup_pkg::t_cell             r_mem [bup_pkg::QDEPTH];
    logic [bup_pkg::QPTR_W-1:0] r_wr, n_wr;
    logic [bup_pkg::QPTR_W-1:0] r_rd, n_rd;
    logic [bup_pkg::QCNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == bup_pkg::QCNT_W'(bup_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cell  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == bup_pkg::QPTR_W'(bup_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == bup_pkg::QPTR_W'(bup_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cell;
        end
    end

endmodule

### hw/rtl/bup_back.sv
// ----------------------------------------------------------------------------
// bup_back: point generator and blend pipeline
// Walks the sub-cell positions of the head cell, one point per cycle while
// not stalled, and blends each in five stages ending in the output register.
// ----------------------------------------------------------------------------
module bup_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_empty,
    input  bup_pkg::t_cell            i_cell,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [bup_pkg::CRD_W-1:0] o_out_row,
    output logic [bup_pkg::CRD_W-1:0] o_out_col,
    output logic [bup_pkg::PIX_W-1:0] o_value,
    output logic                      o_last
);

    localparam int P_W  = bup_pkg::PIX_W + bup_pkg::W_W;
    localparam int MP_W = bup_pkg::SUM_W + bup_pkg::RCP_W;
    localparam int R_W  = bup_pkg::SUM_W + 1;

    typedef struct packed {
        logic                      active;
        logic [bup_pkg::CRD_W-1:0] row;
        logic [bup_pkg::CRD_W-1:0] col;
        logic                      last;
    } t_tag;

    logic [bup_pkg::X_W-1:0] r_x;
    logic [bup_pkg::Y_W-1:0] r_y;

    logic                      r_v1, r_v2, r_v3, r_v4, r_v5;
    t_tag                      r_tag1, r_tag2, r_tag3, r_tag4, r_tag5;
    logic [bup_pkg::PIX_W-1:0] r_a1, r_b1, r_c1, r_d1;
    logic [bup_pkg::W_W-1:0]   r_wa1, r_wb1, r_wc1, r_wd1;
    logic [bup_pkg::SUM_W-1:0] r_pa2, r_pb2, r_pc2, r_pd2;
    logic [bup_pkg::SUM_W-1:0] r_sum3, r_sum4;
    logic [bup_pkg::QE_W-1:0]  r_qe4;
    logic [bup_pkg::PIX_W-1:0] r_val5;

    logic                       w_en;
    logic                       w_issue;
    logic                       w_x_last, w_y_last;
    logic [bup_pkg::WX_W-1:0]   w_wx0, w_wx1;
    logic [bup_pkg::WY_W-1:0]   w_wy0, w_wy1;
    t_tag                       w_tag0;
    logic [P_W-1:0]             w_pa, w_pb, w_pc, w_pd;
    logic [MP_W-1:0]            w_mq;
    logic [R_W-1:0]             w_qn;
    logic [R_W-1:0]             w_rem;
    logic [bup_pkg::QE_W-1:0]   w_q;

    // the whole pipeline holds while the output word waits
    assign w_en     = !(r_v5 && i_out_stall);
    assign w_issue  = w_en && !i_q_empty;
    assign w_x_last = (r_x == bup_pkg::X_W'(bup_pkg::SCALE_H - 1));
    assign w_y_last = (r_y == bup_pkg::Y_W'(bup_pkg::SCALE_V - 1));
    assign o_pop    = w_issue && w_x_last && w_y_last;

    assign w_wx1 = bup_pkg::WX_W'(r_x);
    assign w_wx0 = bup_pkg::WX_W'(bup_pkg::SCALE_H) - w_wx1;
    assign w_wy1 = bup_pkg::WY_W'(r_y);
    assign w_wy0 = bup_pkg::WY_W'(bup_pkg::SCALE_V) - w_wy1;

    assign w_tag0.active = i_cell.active;
    assign w_tag0.row    = i_cell.row + bup_pkg::CRD_W'(r_y);
    assign w_tag0.col    = i_cell.col + bup_pkg::CRD_W'(r_x);
    assign w_tag0.last   = w_x_last && w_y_last;

    assign w_pa = P_W'(r_a1) * P_W'(r_wa1);
    assign w_pb = P_W'(r_b1) * P_W'(r_wb1);
    assign w_pc = P_W'(r_c1) * P_W'(r_wc1);
    assign w_pd = P_W'(r_d1) * P_W'(r_wd1);

    assign w_mq = MP_W'(r_sum3) * MP_W'(bup_pkg::RCP);

    // estimate is at most one low: fix it with the remainder
    assign w_qn  = R_W'(r_qe4) * R_W'(bup_pkg::NPTS);
    assign w_rem = R_W'(r_sum4) - w_qn;
    assign w_q   = (w_rem >= R_W'(bup_pkg::NPTS)) ? r_qe4 + 1'b1 : r_qe4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x  <= '0;
            r_y  <= '0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= !i_q_empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            if (w_issue) begin
                if (w_x_last) begin
                    r_x <= '0;
                    r_y <= w_y_last ? '0 : r_y + 1'b1;
                end else begin
                    r_x <= r_x + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tag1 <= w_tag0;
            r_a1   <= i_cell.a;
            r_b1   <= i_cell.b;
            r_c1   <= i_cell.c;
            r_d1   <= i_cell.d;
            r_wa1  <= bup_pkg::W_W'(w_wx0) * bup_pkg::W_W'(w_wy0);
            r_wb1  <= bup_pkg::W_W'(w_wx1) * bup_pkg::W_W'(w_wy0);
            r_wc1  <= bup_pkg::W_W'(w_wx0) * bup_pkg::W_W'(w_wy1);
            r_wd1  <= bup_pkg::W_W'(w_wx1) * bup_pkg::W_W'(w_wy1);

            r_tag2 <= r_tag1;
            r_pa2  <= bup_pkg::SUM_W'(w_pa);
            r_pb2  <= bup_pkg::SUM_W'(w_pb);
            r_pc2  <= bup_pkg::SUM_W'(w_pc);
            r_pd2  <= bup_pkg::SUM_W'(w_pd);

            r_tag3 <= r_tag2;
            r_sum3 <= r_pa2 + r_pb2 + r_pc2 + r_pd2 + bup_pkg::SUM_W'(bup_pkg::HALF);

            r_tag4 <= r_tag3;
            r_sum4 <= r_sum3;
            r_qe4  <= w_mq[bup_pkg::RCP_SH +: bup_pkg::QE_W];

            r_tag5 <= r_tag4;
            r_val5 <= r_tag4.active ? w_q[bup_pkg::PIX_W-1:0] : '0;
        end
    end

    assign o_out_valid = r_v5;
    assign o_out_row   = r_tag5.row;
    assign o_out_col   = r_tag5.col;
    assign o_value     = r_val5;
    assign o_last      = r_tag5.last;

endmodule

### hw/rtl/bilinear_upscale_window.sv
// ----------------------------------------------------------------------------
// bilinear_upscale_window: streaming 2x2 bilinear upscaler
// Raw pixels in, SCALE_V x SCALE_H interpolated points out per complete cell.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------------
//   cfg     | in        | i_cfg_valid, o_cfg_ready | i_cfg_data (threshold)
//   in      | in        | i_in_valid, o_in_stall   | i_pixel
//   out     | out       | o_out_valid, i_out_stall | o_out_row, o_out_col,
//           |           |                          | o_value, o_last
//
// Each pixel that completes a cell yields SCALE_H*SCALE_V points (16 here),
// issued by the point generator one per cycle while the output is not stalled;
// other pixels yield none. Points pass through the cell queue and blend stages.
// A two-word cell queue lets intake run ahead while points drain.
// Reset is synchronous: clears position, queue and pipeline, threshold to 5.
// An output stall freezes the blend pipeline; intake stalls when the queue fills.
// ----------------------------------------------------------------------------
module bilinear_upscale_window (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [bup_pkg::PIX_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [bup_pkg::PIX_W-1:0] i_pixel,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [bup_pkg::CRD_W-1:0] o_out_row,
    output logic [bup_pkg::CRD_W-1:0] o_out_col,
    output logic [bup_pkg::PIX_W-1:0] o_value,
    output logic                      o_last
);

    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    bup_pkg::t_cell push_cell;
    bup_pkg::t_cell head_cell;

    bup_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_pixel     (i_pixel),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cell      (push_cell)
    );

    bup_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cell  (push_cell),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cell  (head_cell),
        .o_empty (q_empty)
    );

    bup_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_cell      (head_cell),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_value     (o_value),
        .o_last      (o_last)
    );

`ifndef SYNTHESIS
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_full && q_empty))
        else $error("cell queue both full and empty");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("cell queue popped while empty");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("cell queue pushed while full");
`endif

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for bilinear_upscale_window
// Streams raw pixel frames through the block and predicts every upscaled
// point (coordinates, blended value, end of cell run) from a bench-side copy
// of the line buffer and window. It covers the reset threshold, threshold
// extremes, a long output hold with input backpressure, and a frame wrap.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [bup_pkg::CRD_W-1:0] row;
        logic [bup_pkg::CRD_W-1:0] col;
        logic [bup_pkg::PIX_W-1:0] value;
        logic                      last;
    } t_point;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [bup_pkg::PIX_W-1:0] i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [bup_pkg::PIX_W-1:0] i_pixel;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [bup_pkg::CRD_W-1:0] o_out_row;
    logic [bup_pkg::CRD_W-1:0] o_out_col;
    logic [bup_pkg::PIX_W-1:0] o_value;
    logic                      o_last;

    bilinear_upscale_window dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_pixel     (i_pixel),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_value     (o_value),
        .o_last      (o_last)
    );

    // bench copy of the window state
    logic [bup_pkg::PIX_W-1:0] thresh_q;
    logic [bup_pkg::PIX_W-1:0] prev_line [bup_pkg::RAW_WIDTH];
    logic [bup_pkg::PIX_W-1:0] left_px;
    logic [bup_pkg::PIX_W-1:0] diag_px;
    int                        raw_row;
    int                        raw_col;

    t_point expected_points[$];
    int     err_count = 0;
    int     cycle_count = 0;
    bit     tx_calm;
    bit     rx_calm;
    bit     hold_req;
    bit     hold_done;
    int     rx_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // work out the points one accepted pixel causes
    task automatic predict_pixel(input logic [bup_pkg::PIX_W-1:0] px);
        logic [bup_pkg::PIX_W-1:0] a, b, lc;
        logic                      active;
        int                        sum;
        t_point                    p;
        a = diag_px;
        b = prev_line[raw_col];
        lc = left_px;
        if (raw_row >= 1 && raw_col >= 1) begin
            active = (a > thresh_q);
            for (int y = 0; y < bup_pkg::SCALE_V; y++) begin
                for (int x = 0; x < bup_pkg::SCALE_H; x++) begin
                    sum = int'(a) * (bup_pkg::SCALE_H - x) * (bup_pkg::SCALE_V - y)
                        + int'(b) * x * (bup_pkg::SCALE_V - y)
                        + int'(lc) * (bup_pkg::SCALE_H - x) * y
                        + int'(px) * x * y
                        + (bup_pkg::SCALE_H * bup_pkg::SCALE_V) / 2;
                    p.row   = bup_pkg::CRD_W'((raw_row - 1) * bup_pkg::SCALE_V + y);
                    p.col   = bup_pkg::CRD_W'((raw_col - 1) * bup_pkg::SCALE_H + x);
                    p.value = active ?
                        bup_pkg::PIX_W'(sum / (bup_pkg::SCALE_H * bup_pkg::SCALE_V)) : '0;
                    p.last  = (y == bup_pkg::SCALE_V - 1) && (x == bup_pkg::SCALE_H - 1);
                    expected_points.push_back(p);
                end
            end
        end
        diag_px = b;
        prev_line[raw_col] = px;
        left_px = px;
        raw_col++;
        if (raw_col >= bup_pkg::RAW_WIDTH) begin
            raw_col = 0;
            raw_row++;
            if (raw_row >= bup_pkg::RAW_HEIGHT) raw_row = 0;
        end
    endtask

    function automatic int tx_gap();
        int r;
        r = $urandom_range(0, 19);
        if (tx_calm || r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [bup_pkg::PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return thresh_q;
            3: return bup_pkg::PIX_W'(thresh_q + 1);
            default: return bup_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // offer one pixel word; valid stays high afterwards for a back-to-back word
    task automatic send_pixel(input logic [bup_pkg::PIX_W-1:0] px);
        int gap;
        gap = tx_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (o_in_stall);
        predict_pixel(px);
    endtask

    task automatic write_threshold(input logic [bup_pkg::PIX_W-1:0] level);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= level;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        thresh_q = level;
    endtask

    // drop valid, then wait for every point plus the pipeline tail
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // reset threshold, first row, equal/above threshold and pixel extremes
    task automatic test_directed_window();
        logic [bup_pkg::PIX_W-1:0] px [25];
        px = '{8'd5, 8'd6, 8'd255, 8'd255, 8'd0, 8'd255, 8'd1, 8'd128,
               8'd37, 8'd200, 8'd0, 8'd255, 8'd17, 8'd90, 8'd254, 8'd3,
               8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd254, 8'd1,
               8'd128};
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        foreach (px[i]) send_pixel(px[i]);
        wait_idle();
    endtask

    // several threshold settings, extremes first, random pixels in each
    task automatic test_threshold_sweep();
        logic [bup_pkg::PIX_W-1:0] levels [5];
        levels = '{8'd0, 8'd255, bup_pkg::PIX_W'($urandom_range(1, 254)), 8'd128,
                   bup_pkg::PIX_W'($urandom_range(0, 40))};
        for (int p = 0; p < 5; p++) begin
            write_threshold(levels[p]);
            tx_calm = (p == 1);
            rx_calm = (p == 1) || (p == 3);
            repeat (42) send_pixel(rand_pixel());
            wait_idle();
        end
    endtask

    // long output hold with input offered back to back; crosses the frame end
    task automatic test_output_hold();
        write_threshold(bup_pkg::PIX_W'($urandom_range(0, 60)));
        tx_calm = 1'b1;
        rx_calm = 1'b0;
        hold_req = 1'b1;
        repeat (40) send_pixel(rand_pixel());
        tx_calm = 1'b0;
        wait_idle();
    endtask

    // receiver stall: random short and long stalls, calm stretches, one hold
    initial begin
        int r;
        i_out_stall <= 1'b0;
        rx_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (rx_left > 0) begin
                rx_left--;
                i_out_stall <= 1'b1;
            end else if (rx_calm) begin
                i_out_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 31);
                if (r < 20) begin
                    i_out_stall <= 1'b0;
                end else if (r < 30) begin
                    i_out_stall <= 1'b1;
                    rx_left = $urandom_range(0, 3);
                end else begin
                    i_out_stall <= 1'b1;
                    rx_left = $urandom_range(10, 40);
                end
            end
        end
    end

    // compare each accepted point with the oldest prediction
    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_points.size() == 0) begin
                $error("unexpected point row %0d col %0d value %0d last %0d",
                       o_out_row, o_out_col, o_value, o_last);
                err_count++;
            end else begin
                want = expected_points.pop_front();
                if (o_out_row !== want.row) begin
                    $error("out_row: expected %0d, got %0d", want.row, o_out_row);
                    err_count++;
                end
                if (o_out_col !== want.col) begin
                    $error("out_col: expected %0d, got %0d", want.col, o_out_col);
                    err_count++;
                end
                if (o_value !== want.value) begin
                    $error("value: expected %0d, got %0d", want.value, o_value);
                    err_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bilinear_upscale_window: mismatch");
            $finish;
        end
    end

    initial begin
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        hold_req = 1'b0;
        thresh_q = bup_pkg::PIX_W'(bup_pkg::THRESH_RST);
        left_px = '0;
        diag_px = '0;
        raw_row = 0;
        raw_col = 0;
        foreach (prev_line[i]) prev_line[i] = '0;
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_pixel <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_window();
        test_threshold_sweep();
        test_output_hold();

        if (err_count == 0) begin
            $display("bilinear_upscale_window: match");
        end else begin
            $display("bilinear_upscale_window: mismatch");
        end
        $finish;
    end

endmodule
